@@ hw/rtl/spd_pkg.sv @@
// Package: shared types and constants of the serial packet deframer.
package spd_pkg;

  localparam int unsigned COUNTER_BITS_DEFAULT = 16;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned LEN_BITS = 16;
  localparam int unsigned COUNT_OUT_BITS = 16;

  localparam logic [BYTE_BITS-1:0] SYNC_BYTE = 8'hFF;
  localparam logic [LEN_BITS-1:0] MAX_LENGTH_RESET = 16'd1000;

  typedef logic [BYTE_BITS-1:0] byte_t;
  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [COUNT_OUT_BITS-1:0] count_out_t;

  typedef enum logic [1:0] {
    KIND_CONSOLE = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_LEN_ERR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_CSUM   = 3'd3,
    PH_DATA   = 3'd4
  } phase_t;

endpackage

@@ hw/rtl/spd_if.sv @@
// Interfaces: received byte, deframed result and configuration write channels.
interface spd_rx_if;
  import spd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface spd_tx_if;
  import spd_pkg::*;
  logic       valid;
  logic       ready;
  kind_t      kind;
  byte_t      data_byte;
  logic       last;
  logic       checksum_good;
  count_out_t good_count;
  count_out_t bad_count;
  modport source (output valid, output kind, output data_byte, output last,
                  output checksum_good, output good_count, output bad_count,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input last,
                input checksum_good, input good_count, input bad_count,
                output ready);
endinterface

interface spd_cfg_if;
  import spd_pkg::*;
  logic valid;
  logic ready;
  len_t max_length;
  modport source (output valid, output max_length, input ready);
  modport sink (input valid, input max_length, output ready);
endinterface

@@ hw/rtl/serial_packet_deframer_top.sv @@
// Top level: sync/length/checksum deframer for a serial byte stream.
//
//   channel  dir  word                          notes
//   rx       in   rx_byte                       one serial byte per word
//   tx       out  kind, data_byte, last, ...    zero or one word per rx word
//   cfg      in   max_length                    always ready
//
// One rx word per cycle while tx is not stalled; tx valid follows the rx
// accept through the input register, then the result register. Sync, length
// and checksum bytes produce no tx word, but length > max_length gives LEN_ERR.
// A stalled tx holds the result register; the input register then holds too
// and rx ready drops once it is full.
// rst is synchronous: phase returns to idle, counters clear, max_length = 1000.
module serial_packet_deframer_top #(
  parameter int unsigned COUNTER_BITS = spd_pkg::COUNTER_BITS_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  spd_rx_if.sink  rx,
  spd_tx_if.source tx,
  spd_cfg_if.sink cfg
);
  import spd_pkg::*;

  // configuration
  len_t max_length;

  // input register
  logic  in_valid;
  byte_t in_byte;

  // deframer state
  phase_t phase, phase_next;
  len_t   packet_length, packet_length_next;
  byte_t  expected_sum, expected_sum_next;
  byte_t  running_sum, running_sum_next;
  len_t   received_count, received_count_next;
  logic [COUNTER_BITS-1:0] good_packets, good_packets_next;
  logic [COUNTER_BITS-1:0] bad_packets, bad_packets_next;

  // result
  logic  res_valid;
  kind_t res_kind;
  byte_t res_data;
  logic  res_last;
  logic  res_good;
  count_out_t good_low, bad_low;

  // result register
  logic       out_valid;
  kind_t      out_kind;
  byte_t      out_data;
  logic       out_last;
  logic       out_good;
  count_out_t out_good_count;
  count_out_t out_bad_count;

  logic out_free;
  logic step;
  len_t len_full;

  assign out_free = !out_valid || tx.ready;
  assign step     = in_valid && out_free;
  assign rx.ready = !in_valid || out_free;
  assign cfg.ready = 1'b1;
  assign len_full = packet_length | len_t'(in_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg.valid) begin
      max_length <= cfg.max_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      case (phase)
        PH_LEN_HI: phase_next = PH_LEN_LO;
        PH_LEN_LO: phase_next = (len_full > max_length) ? PH_IDLE : PH_CSUM;
        PH_CSUM:   phase_next = PH_DATA;
        PH_DATA:   phase_next = (received_count_next >= packet_length) ? PH_IDLE : PH_DATA;
        default:   phase_next = (in_byte == SYNC_BYTE) ? PH_LEN_HI : PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    packet_length_next  = packet_length;
    expected_sum_next   = expected_sum;
    running_sum_next    = running_sum;
    received_count_next = received_count;
    good_packets_next   = good_packets;
    bad_packets_next    = bad_packets;
    res_valid = 1'b0;
    res_kind  = KIND_CONSOLE;
    res_data  = in_byte;
    res_last  = 1'b0;
    res_good  = 1'b0;
    case (phase)
      PH_LEN_HI: begin
        packet_length_next = {in_byte, byte_t'(0)};
      end
      PH_LEN_LO: begin
        packet_length_next = len_full;
        if (len_full > max_length) begin
          res_valid = 1'b1;
          res_kind  = KIND_LEN_ERR;
          res_data  = '0;
        end
      end
      PH_CSUM: begin
        expected_sum_next   = in_byte;
        running_sum_next    = '0;
        received_count_next = '0;
      end
      PH_DATA: begin
        running_sum_next    = running_sum + in_byte;
        received_count_next = received_count + len_t'(1);
        res_valid = 1'b1;
        res_kind  = KIND_PAYLOAD;
        // final byte: judge the sum and bump one counter
        if (received_count_next >= packet_length) begin
          res_last = 1'b1;
          res_good = (running_sum_next == expected_sum);
          if (res_good) begin
            good_packets_next = good_packets + COUNTER_BITS'(1);
          end else begin
            bad_packets_next = bad_packets + COUNTER_BITS'(1);
          end
        end
      end
      default: begin
        res_valid = (in_byte != SYNC_BYTE);
      end
    endcase
  end

  generate
    if (COUNTER_BITS >= COUNT_OUT_BITS) begin : g_cnt_wide
      assign good_low = good_packets_next[COUNT_OUT_BITS-1:0];
      assign bad_low  = bad_packets_next[COUNT_OUT_BITS-1:0];
    end else begin : g_cnt_narrow
      assign good_low = {{(COUNT_OUT_BITS-COUNTER_BITS){1'b0}}, good_packets_next};
      assign bad_low  = {{(COUNT_OUT_BITS-COUNTER_BITS){1'b0}}, bad_packets_next};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      packet_length  <= '0;
      expected_sum   <= '0;
      running_sum    <= '0;
      received_count <= '0;
      good_packets   <= '0;
      bad_packets    <= '0;
    end else if (step) begin
      phase          <= phase_next;
      packet_length  <= packet_length_next;
      expected_sum   <= expected_sum_next;
      running_sum    <= running_sum_next;
      received_count <= received_count_next;
      good_packets   <= good_packets_next;
      bad_packets    <= bad_packets_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res_valid;
    end
  end

  // load only when a word is produced
  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_kind       <= res_kind;
      out_data       <= res_data;
      out_last       <= res_last;
      out_good       <= res_good;
      out_good_count <= good_low;
      out_bad_count  <= bad_low;
    end
  end

  assign tx.valid         = out_valid;
  assign tx.kind          = out_kind;
  assign tx.data_byte     = out_data;
  assign tx.last          = out_last;
  assign tx.checksum_good = out_good;
  assign tx.good_count    = out_good_count;
  assign tx.bad_count     = out_bad_count;

endmodule
